// ===== rtl/core/wrt_pkg.sv =====
// Types and constants shared by the windowed rejection trigger modules.
package wrt_pkg;

  localparam int unsigned MaxWindow = 64;

  localparam int unsigned CntW  = 7;
  localparam int unsigned RateW = 17;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;
  localparam int unsigned TrigW = 32;
  localparam int unsigned ProdW = 24;

  localparam logic [RateW-1:0] ONE_Q16 = 17'd65536;

  localparam logic [CfgIdxW-1:0] REG_WINDOW_LENGTH   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RATIO_THRESHOLD = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_IDLE_RATE       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BOOST_RATE      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FEATURE_ENABLE  = 3'd4;

  localparam logic FUNC_OBSERVE = 1'b0;
  localparam logic FUNC_CLEAR   = 1'b1;

  localparam logic [CntW-1:0]  RST_WINDOW_LENGTH   = 7'd16;
  localparam logic [RateW-1:0] RST_RATIO_THRESHOLD = 17'd32768;
  localparam logic [RateW-1:0] RST_IDLE_RATE       = 17'd6554;
  localparam logic [RateW-1:0] RST_BOOST_RATE      = 17'd13107;
  localparam logic             RST_FEATURE_ENABLE  = 1'b1;

  typedef struct packed {
    logic func;
    logic rejected;
  } in_item_t;

  typedef struct packed {
    logic             is_active;
    logic [RateW-1:0] rate_out;
    logic [CntW-1:0]  reject_total;
    logic [CntW-1:0]  fill_level;
    logic [TrigW-1:0] trigger_total;
  } out_item_t;

  typedef struct packed {
    logic [CntW-1:0]  window_length;
    logic [RateW-1:0] ratio_threshold;
    logic [RateW-1:0] idle_rate;
    logic [RateW-1:0] boost_rate;
    logic             feature_enable;
  } cfg_t;

  // Broadcast to every window cell.
  typedef struct packed {
    logic            obs;     // an outcome enters this cycle
    logic            pop;     // oldest outcome leaves, chain shifts toward cell 0
    logic [CntW-1:0] target;  // cell that takes the new outcome
    logic            din;     // new outcome
  } cell_ctrl_t;

endpackage

// ===== rtl/core/wrt_cell.sv =====
// One window cell: holds one outcome, shifts toward cell 0 on a pop.
module wrt_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                clk_i,
  input  wrt_pkg::cell_ctrl_t ctrl_i,
  input  logic                next_i,
  output logic                q_o
);

  logic bit_q, bit_d;
  logic at_target;

  assign at_target = (int'(ctrl_i.target) == IDX);

  always_comb begin
    bit_d = bit_q;
    if (ctrl_i.obs) begin
      if (at_target) begin
        bit_d = ctrl_i.din;
      end else if (ctrl_i.pop) begin
        bit_d = next_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q <= bit_d;
  end

  assign q_o = bit_q;

endmodule

// ===== rtl/core/wrt_ctrl.sv =====
// Window counters, ratio test, trigger counter and rate selection.
module wrt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  wrt_pkg::in_item_t    item_i,
  input  wrt_pkg::cfg_t        cfg_i,
  input  logic                 front_i,
  output wrt_pkg::cell_ctrl_t  cell_ctrl_o,
  output wrt_pkg::out_item_t   result_o
);

  logic [wrt_pkg::CntW-1:0]  held_q, held_d;
  logic [wrt_pkg::CntW-1:0]  reject_q, reject_d;
  logic                      active_q, active_d;
  logic [wrt_pkg::TrigW-1:0] edge_q, edge_d;

  logic [wrt_pkg::CntW-1:0]  len;
  logic                      obs, pop;
  logic [wrt_pkg::ProdW-1:0] lhs, rhs;
  logic [wrt_pkg::RateW:0]   rate_sum;
  logic [wrt_pkg::RateW-1:0] rate;

  always_comb begin
    if (cfg_i.window_length == '0) begin
      len = wrt_pkg::CntW'(1);
    end else if (int'(cfg_i.window_length) > wrt_pkg::MaxWindow) begin
      len = wrt_pkg::CntW'(wrt_pkg::MaxWindow);
    end else begin
      len = cfg_i.window_length;
    end
  end

  assign obs = fire_i && (item_i.func == wrt_pkg::FUNC_OBSERVE) && cfg_i.feature_enable;
  assign pop = obs && (held_q >= len);

  assign cell_ctrl_o.obs    = obs;
  assign cell_ctrl_o.pop    = pop;
  assign cell_ctrl_o.target = pop ? (held_q - wrt_pkg::CntW'(1)) : held_q;
  assign cell_ctrl_o.din    = item_i.rejected;

  // count * 1.0 >= threshold * length
  assign lhs = wrt_pkg::ProdW'({reject_d, 16'h0000});
  assign rhs = wrt_pkg::ProdW'(cfg_i.ratio_threshold) * wrt_pkg::ProdW'(len);

  always_comb begin
    held_d   = held_q;
    reject_d = reject_q;
    active_d = active_q;
    edge_d   = edge_q;
    if (fire_i && item_i.func == wrt_pkg::FUNC_CLEAR) begin
      held_d   = '0;
      reject_d = '0;
      active_d = 1'b0;
    end else if (obs) begin
      held_d   = pop ? held_q : held_q + wrt_pkg::CntW'(1);
      reject_d = reject_q + wrt_pkg::CntW'(item_i.rejected)
                 - wrt_pkg::CntW'(pop & front_i);
      active_d = (held_d == len) && (lhs >= rhs);
      if (!active_q && active_d && edge_q != '1) begin
        edge_d = edge_q + wrt_pkg::TrigW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= '0;
      reject_q <= '0;
      active_q <= 1'b0;
      edge_q   <= '0;
    end else begin
      held_q   <= held_d;
      reject_q <= reject_d;
      active_q <= active_d;
      edge_q   <= edge_d;
    end
  end

  always_comb begin
    rate_sum = {1'b0, cfg_i.idle_rate};
    if (active_d) begin
      rate_sum = {1'b0, cfg_i.idle_rate} + {1'b0, cfg_i.boost_rate};
    end
    if (rate_sum > {1'b0, wrt_pkg::ONE_Q16}) begin
      rate = wrt_pkg::ONE_Q16;
    end else begin
      rate = rate_sum[wrt_pkg::RateW-1:0];
    end
  end

  assign result_o.is_active     = active_d;
  assign result_o.rate_out      = rate;
  assign result_o.reject_total  = reject_d;
  assign result_o.fill_level    = held_d;
  assign result_o.trigger_total = edge_d;

endmodule

// ===== rtl/core/windowed_rejection_trigger_top.sv =====
// Top level: config registers, window cell chain, control and output buffer.
// Results go to the output register, or to the skid entry on a stall.
// One item per cycle while skid is empty; the window state updates at accept.
// A two-entry output buffer keeps in_ready_o high while one result waits.
// Reset: config to defaults, counters and active cleared; cells are not reset
// (only cells written since the last clear are ever read).
module windowed_rejection_trigger_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  wrt_pkg::in_item_t               in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output wrt_pkg::out_item_t              out_item_o,
  input  logic                            cfg_we_i,
  input  logic [wrt_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [wrt_pkg::CfgDataW-1:0]    cfg_wdata_i
);

  wrt_pkg::cfg_t       cfg_q;
  wrt_pkg::cell_ctrl_t cell_ctrl;
  wrt_pkg::out_item_t  result;
  wrt_pkg::out_item_t  out_q, skid_q;
  logic                out_v_q, skid_v_q;
  logic                in_fire;
  logic [wrt_pkg::MaxWindow-1:0] cell_q;

  assign in_ready_o = !skid_v_q;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_length   <= wrt_pkg::RST_WINDOW_LENGTH;
      cfg_q.ratio_threshold <= wrt_pkg::RST_RATIO_THRESHOLD;
      cfg_q.idle_rate       <= wrt_pkg::RST_IDLE_RATE;
      cfg_q.boost_rate      <= wrt_pkg::RST_BOOST_RATE;
      cfg_q.feature_enable  <= wrt_pkg::RST_FEATURE_ENABLE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wrt_pkg::REG_WINDOW_LENGTH:   cfg_q.window_length <= cfg_wdata_i[wrt_pkg::CntW-1:0];
        wrt_pkg::REG_RATIO_THRESHOLD: cfg_q.ratio_threshold <= cfg_wdata_i;
        wrt_pkg::REG_IDLE_RATE:       cfg_q.idle_rate <= cfg_wdata_i;
        wrt_pkg::REG_BOOST_RATE:      cfg_q.boost_rate <= cfg_wdata_i;
        wrt_pkg::REG_FEATURE_ENABLE:  cfg_q.feature_enable <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Oldest outcome always sits in cell 0.
  for (genvar i = 0; i < wrt_pkg::MaxWindow; i++) begin : g_cell
    logic next;
    if (i == wrt_pkg::MaxWindow - 1) begin : g_last
      assign next = cell_q[i];
    end else begin : g_mid
      assign next = cell_q[i+1];
    end
    wrt_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl),
      .next_i (next),
      .q_o    (cell_q[i])
    );
  end

  wrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_fire),
    .item_i      (in_item_i),
    .cfg_i       (cfg_q),
    .front_i     (cell_q[0]),
    .cell_ctrl_o (cell_ctrl),
    .result_o    (result)
  );

  // Output register plus skid entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      out_q <= skid_v_q ? skid_q : result;
    end else if (in_fire) begin
      skid_q <= result;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry held without an output item");

  a_reject_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q.reject_total <= out_q.fill_level))
    else $error("reject total exceeds fill level");

  a_rate_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q.rate_out <= wrt_pkg::ONE_Q16))
    else $error("rate above 1.0");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i && in_fire && !skid_v_q) |=> skid_v_q)
    else $error("stalled item not captured in skid entry");

endmodule

// ===== sim/wrt_trigger_monitor.sv =====
// Monitor for the windowed rejection trigger: predicts every report and checks the output.
module wrt_trigger_monitor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  wrt_pkg::in_item_t            in_item_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  wrt_pkg::out_item_t           out_item_i,
  input  logic                         cfg_we_i,
  input  logic [wrt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wrt_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);

  localparam int unsigned SlotW = $clog2(wrt_pkg::MaxWindow);

  wrt_pkg::cfg_t             regs;
  logic                      outcomes [wrt_pkg::MaxWindow];
  logic [SlotW-1:0]          slot;
  logic [wrt_pkg::CntW-1:0]  held;
  logic [wrt_pkg::CntW-1:0]  rejects;
  logic                      active;
  logic [wrt_pkg::TrigW-1:0] edges;
  wrt_pkg::out_item_t        due_reports [$];
  wrt_pkg::out_item_t        want;
  int unsigned               fails;

  // Window state after one event, and the report it produces.
  function automatic wrt_pkg::out_item_t next_report(input wrt_pkg::in_item_t ev);
    int unsigned        len;
    logic [SlotW-1:0]   front;
    int unsigned        rate;
    logic               oldest;
    logic               prev_active;
    wrt_pkg::out_item_t rep;
    len = 32'(regs.window_length);
    if (len == 0) len = 1;
    if (len > wrt_pkg::MaxWindow) len = wrt_pkg::MaxWindow;
    if (ev.func == wrt_pkg::FUNC_CLEAR) begin
      slot = '0;
      held = '0;
      rejects = '0;
      active = 1'b0;
    end else if (regs.feature_enable) begin
      front = slot - held[SlotW-1:0];
      oldest = outcomes[front];
      prev_active = active;
      outcomes[slot] = ev.rejected;
      slot = slot + SlotW'(1);
      held = held + wrt_pkg::CntW'(1);
      rejects = rejects + wrt_pkg::CntW'(ev.rejected);
      // a shrunk window only drops one outcome per observe
      if (32'(held) > len) begin
        rejects = rejects - wrt_pkg::CntW'(oldest);
        held = held - wrt_pkg::CntW'(1);
      end
      active = (32'(held) == len) &&
               (longint'(rejects) * 65536 >=
                longint'(regs.ratio_threshold) * longint'(len));
      if (!prev_active && active && edges != {wrt_pkg::TrigW{1'b1}}) begin
        edges = edges + wrt_pkg::TrigW'(1);
      end
    end
    rate = 32'(regs.idle_rate);
    if (active) rate = rate + 32'(regs.boost_rate);
    if (rate > 32'(wrt_pkg::ONE_Q16)) rate = 32'(wrt_pkg::ONE_Q16);
    rep.is_active = active;
    rep.rate_out = wrt_pkg::RateW'(rate);
    rep.reject_total = rejects;
    rep.fill_level = held;
    rep.trigger_total = edges;
    return rep;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      fails++;
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs = '{wrt_pkg::RST_WINDOW_LENGTH, wrt_pkg::RST_RATIO_THRESHOLD,
               wrt_pkg::RST_IDLE_RATE, wrt_pkg::RST_BOOST_RATE,
               wrt_pkg::RST_FEATURE_ENABLE};
      slot = '0;
      held = '0;
      rejects = '0;
      active = 1'b0;
      edges = '0;
      fails = 0;
      due_reports.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      // a report is registered before it leaves, so take it before its own item
      if (out_valid_i && out_ready_i) begin
        if (due_reports.size() == 0) begin
          fails++;
          $display("%0t: report expected none got %p", $time, out_item_i);
        end else begin
          want = due_reports[0];
          due_reports.delete(0);
          check_field("is_active", 32'(want.is_active), 32'(out_item_i.is_active));
          check_field("rate_out", 32'(want.rate_out), 32'(out_item_i.rate_out));
          check_field("reject_total", 32'(want.reject_total),
                      32'(out_item_i.reject_total));
          check_field("fill_level", 32'(want.fill_level), 32'(out_item_i.fill_level));
          check_field("trigger_total", want.trigger_total, out_item_i.trigger_total);
        end
      end
      if (in_valid_i && in_ready_i) due_reports = {due_reports, next_report(in_item_i)};
      if (cfg_we_i) begin
        case (cfg_idx_i)
          wrt_pkg::REG_WINDOW_LENGTH:
            regs.window_length = cfg_wdata_i[wrt_pkg::CntW-1:0];
          wrt_pkg::REG_RATIO_THRESHOLD:
            regs.ratio_threshold = cfg_wdata_i[wrt_pkg::RateW-1:0];
          wrt_pkg::REG_IDLE_RATE:
            regs.idle_rate = cfg_wdata_i[wrt_pkg::RateW-1:0];
          wrt_pkg::REG_BOOST_RATE:
            regs.boost_rate = cfg_wdata_i[wrt_pkg::RateW-1:0];
          wrt_pkg::REG_FEATURE_ENABLE:
            regs.feature_enable = cfg_wdata_i[0];
          default: ;
        endcase
      end
      fail_count_o <= fails;
      pending_o <= due_reports.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top: directed and random events into the trigger, stall control and verdict.
module tb;

  localparam int unsigned QuietLimit = 500;
  localparam int unsigned RandomItems = 1250;

  logic                         clk_i;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  wrt_pkg::in_item_t            in_item_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  wrt_pkg::out_item_t           out_item_o;
  logic                         cfg_we_i = 1'b0;
  logic [wrt_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [wrt_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles = 0;
  int unsigned ready_hold;
  int unsigned rx_draw;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  windowed_rejection_trigger_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  wrt_trigger_monitor mon (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_i   (out_item_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Receiver: after each report, ready may be held low for a random stretch; never when rx_calm is set.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      ready_hold <= 0;
    end else if (out_valid_o && out_ready_i) begin
      rx_draw = rx_calm ? 0 : $urandom_range(0, 17);
      out_ready_i <= (rx_draw == 0);
      ready_hold <= rx_draw;
    end else if (ready_hold > 1) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready_i <= 1'b1;
      ready_hold <= 0;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic wrt_pkg::cfg_t settings(input int unsigned len, input int unsigned thr,
                                             input int unsigned idle, input int unsigned boost,
                                             input bit en);
    wrt_pkg::cfg_t c;
    c.window_length = wrt_pkg::CntW'(len);
    c.ratio_threshold = wrt_pkg::RateW'(thr);
    c.idle_rate = wrt_pkg::RateW'(idle);
    c.boost_rate = wrt_pkg::RateW'(boost);
    c.feature_enable = en;
    return c;
  endfunction

  // Valid is only dropped ahead of a gap, so back-to-back items keep it high.
  task automatic send_event(input logic f, input logic rej);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= '{func: f, rejected: rej};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic reprogram(input wrt_pkg::cfg_t c);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= wrt_pkg::REG_WINDOW_LENGTH;
    cfg_wdata_i <= wrt_pkg::CfgDataW'(c.window_length);
    @(posedge clk_i);
    cfg_idx_i <= wrt_pkg::REG_RATIO_THRESHOLD;
    cfg_wdata_i <= c.ratio_threshold;
    @(posedge clk_i);
    cfg_idx_i <= wrt_pkg::REG_IDLE_RATE;
    cfg_wdata_i <= c.idle_rate;
    @(posedge clk_i);
    cfg_idx_i <= wrt_pkg::REG_BOOST_RATE;
    cfg_wdata_i <= c.boost_rate;
    @(posedge clk_i);
    cfg_idx_i <= wrt_pkg::REG_FEATURE_ENABLE;
    cfg_wdata_i <= wrt_pkg::CfgDataW'(c.feature_enable);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    wrt_pkg::cfg_t plan;
    int unsigned   counted;
    int unsigned   reject_pct;
    int unsigned   pick;
    int unsigned   burst;
    counted = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings
    send_event(wrt_pkg::FUNC_OBSERVE, 1'b1);
    send_event(wrt_pkg::FUNC_OBSERVE, 1'b0);

    // two-deep window at one half, rate sum above 1.0
    reprogram(settings(2, 32768, 65535, 65536, 1'b1));
    send_event(wrt_pkg::FUNC_OBSERVE, 1'b1);
    send_event(wrt_pkg::FUNC_OBSERVE, 1'b1);
    send_event(wrt_pkg::FUNC_OBSERVE, 1'b0);
    send_event(wrt_pkg::FUNC_OBSERVE, 1'b0);
    send_event(wrt_pkg::FUNC_OBSERVE, 1'b1);
    send_event(wrt_pkg::FUNC_OBSERVE, 1'b1);
    send_event(wrt_pkg::FUNC_CLEAR, 1'b1);
    send_event(wrt_pkg::FUNC_OBSERVE, 1'b1);

    // length zero acts as one, threshold exactly 1.0
    reprogram(settings(0, 65536, 0, 0, 1'b1));
    send_event(wrt_pkg::FUNC_OBSERVE, 1'b1);
    send_event(wrt_pkg::FUNC_OBSERVE, 1'b0);
    send_event(wrt_pkg::FUNC_OBSERVE, 1'b1);

    // oversize length, unreachable threshold, idle rate above 1.0, disabled
    reprogram(settings(127, 131071, 131071, 131071, 1'b0));
    send_event(wrt_pkg::FUNC_OBSERVE, 1'b1);
    send_event(wrt_pkg::FUNC_CLEAR, 1'b0);
    send_event(wrt_pkg::FUNC_OBSERVE, 1'b0);

    // zero threshold activates as soon as the window fills
    reprogram(settings(3, 0, 100, 200, 1'b1));
    send_event(wrt_pkg::FUNC_OBSERVE, 1'b0);
    send_event(wrt_pkg::FUNC_OBSERVE, 1'b0);
    send_event(wrt_pkg::FUNC_OBSERVE, 1'b0);

    // window shrunk while filled stays inactive until cleared
    reprogram(settings(1, 0, 65536, 1, 1'b1));
    send_event(wrt_pkg::FUNC_OBSERVE, 1'b1);
    send_event(wrt_pkg::FUNC_OBSERVE, 1'b0);
    send_event(wrt_pkg::FUNC_CLEAR, 1'b0);
    send_event(wrt_pkg::FUNC_OBSERVE, 1'b1);

    while (counted < RandomItems) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) plan.window_length = wrt_pkg::CntW'($urandom_range(1, 12));
      else if (pick < 15) plan.window_length = wrt_pkg::CntW'($urandom_range(13, 64));
      else if (pick < 16) plan.window_length = wrt_pkg::CntW'(64);
      else if (pick < 17) plan.window_length = '0;
      else plan.window_length = wrt_pkg::CntW'($urandom_range(65, 127));
      pick = $urandom_range(0, 9);
      if (pick < 7) plan.ratio_threshold = wrt_pkg::RateW'($urandom_range(0, 65536));
      else if (pick < 8) plan.ratio_threshold = '0;
      else if (pick < 9) plan.ratio_threshold = wrt_pkg::ONE_Q16;
      else plan.ratio_threshold = wrt_pkg::RateW'($urandom_range(65537, 131071));
      plan.idle_rate = wrt_pkg::RateW'(($urandom_range(0, 3) == 0) ?
                                       $urandom_range(0, 131071) :
                                       $urandom_range(0, 65536));
      plan.boost_rate = wrt_pkg::RateW'(($urandom_range(0, 3) == 0) ?
                                        $urandom_range(0, 131071) :
                                        $urandom_range(0, 65536));
      plan.feature_enable = ($urandom_range(0, 7) != 0);
      reprogram(plan);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) reject_pct = 0;
      else if (pick == 1) reject_pct = 100;
      else reject_pct = $urandom_range(0, 100);
      burst = $urandom_range(40, 160);
      if (burst > RandomItems - counted) burst = RandomItems - counted;
      repeat (burst) begin
        if ($urandom_range(0, 99) < 3) begin
          send_event(wrt_pkg::FUNC_CLEAR, 1'($urandom_range(0, 1)));
        end else begin
          send_event(wrt_pkg::FUNC_OBSERVE, $urandom_range(0, 99) < reject_pct);
        end
        counted++;
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
